FILE: rtl/ptz_command_frame_encoder_top_defines.svh
// assertion macros used by the checker file
`ifndef PTZ_COMMAND_FRAME_ENCODER_TOP_DEFINES_SVH
`define PTZ_COMMAND_FRAME_ENCODER_TOP_DEFINES_SVH

// property checked outside reset
`define PCFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that also covers the reset cycles
`define PCFE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/pcfe_pkg.sv
package pcfe_pkg;

  localparam int FRAME_BYTES = 9;
  localparam int IDX_W       = $clog2(FRAME_BYTES);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam logic CFG_DEVICE_ADDRESS = 1'b0;
  localparam logic CFG_DEFAULT_SPEED  = 1'b1;

  localparam logic [7:0] DEVICE_ADDRESS_RST = 8'd1;
  localparam logic [7:0] DEFAULT_SPEED_RST  = 8'd50;

  // frame constants
  localparam logic [7:0] START_CODE     = 8'ha0;
  localparam logic [7:0] GRP_CAMERA     = 8'h01;
  localparam logic [7:0] GRP_PRESET     = 8'h03;
  localparam logic [7:0] SUB_MOTION     = 8'h02;
  localparam logic [7:0] SUB_SET_PRESET = 8'h50;
  localparam logic [7:0] SUB_GOTO       = 8'h19;
  localparam logic [7:0] LENS_TELE      = 8'h20;
  localparam logic [7:0] LENS_WIDE      = 8'h40;
  localparam logic [7:0] LENS_IRIS_OPEN = 8'h08;
  localparam logic [7:0] LENS_IRIS_CLS  = 8'h10;
  localparam logic [7:0] LENS_FAR       = 8'h01;
  localparam logic [7:0] LENS_NEAR      = 8'h02;
  localparam logic [7:0] LENS_STOP      = 8'h00;
  localparam logic [7:0] FILL_BYTE      = 8'hff;

  typedef enum logic [4:0] {
    CMD_PAN_LEFT    = 5'd0,
    CMD_PAN_RIGHT   = 5'd1,
    CMD_TILT_UP     = 5'd2,
    CMD_TILT_DOWN   = 5'd3,
    CMD_LEFT_UP     = 5'd4,
    CMD_LEFT_DOWN   = 5'd5,
    CMD_RIGHT_UP    = 5'd6,
    CMD_RIGHT_DOWN  = 5'd7,
    CMD_ZOOM_TELE   = 5'd8,
    CMD_ZOOM_WIDE   = 5'd9,
    CMD_IRIS_OPEN   = 5'd10,
    CMD_IRIS_CLOSE  = 5'd11,
    CMD_FOCUS_FAR   = 5'd12,
    CMD_FOCUS_NEAR  = 5'd13,
    CMD_STOP        = 5'd14,
    CMD_SET_PRESET  = 5'd15,
    CMD_GOTO_PRESET = 5'd16
  } pcfe_cmd_t;

  localparam logic [7:0] DIR_TABLE [0:7] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h05, 8'h09, 8'h06, 8'h0a
  };

  localparam logic [7:0] SPEED_TABLE [0:9] = '{
    8'h0f, 8'h19, 8'h32, 8'h4b, 8'h64, 8'h7d, 8'h96, 8'haf, 8'hc8, 8'hff
  };

  // one classified frame waiting for the serializer
  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [7:0] b5;
    logic [7:0] b6;
    logic [7:0] b7;
    logic [7:0] chk;
  } pcfe_entry_t;

  // speed byte: index s/10-1 clamped to 0..9, found by threshold compares
  function automatic logic [7:0] speed_lookup(input logic [7:0] s);
    logic [3:0] idx;
    idx = '0;
    for (int t = 2; t <= 10; t++) begin
      if (s >= 8'(t * 10)) idx = 4'(t - 1);
    end
    return SPEED_TABLE[idx];
  endfunction

endpackage

FILE: rtl/pcfe_front.sv
module pcfe_front
  import pcfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [4:0]  in_cmd,
  input  logic [7:0]  in_param,
  input  logic [7:0]  device_address,
  input  logic [7:0]  default_speed,
  output logic        q_push,
  output pcfe_entry_t q_wdata,
  input  logic        q_full
);

  logic        valid_r, valid_nxt;
  pcfe_entry_t ent_r;
  pcfe_entry_t ent_nxt;
  logic        accept;
  logic [7:0]  spd;
  logic [7:0]  sum;

  assign in_full = valid_r && q_full;
  assign accept  = in_push && !in_full;
  assign q_push  = valid_r && !q_full;
  assign q_wdata = ent_r;

  assign spd = speed_lookup((in_param != 8'd0) ? in_param : default_speed);

  // classify the command into its five body bytes and checksum
  always_comb begin
    ent_nxt      = '0;
    ent_nxt.addr = device_address;
    case (in_cmd)
      CMD_PAN_LEFT, CMD_PAN_RIGHT, CMD_TILT_UP, CMD_TILT_DOWN,
      CMD_LEFT_UP, CMD_LEFT_DOWN, CMD_RIGHT_UP, CMD_RIGHT_DOWN: begin
        ent_nxt.b3 = GRP_CAMERA;
        ent_nxt.b4 = SUB_MOTION;
        ent_nxt.b5 = DIR_TABLE[in_cmd[2:0]];
        ent_nxt.b6 = (in_cmd == CMD_TILT_UP || in_cmd == CMD_TILT_DOWN) ? 8'd0 : spd;
        ent_nxt.b7 = (in_cmd == CMD_PAN_LEFT || in_cmd == CMD_PAN_RIGHT) ? 8'd0 : spd;
      end
      CMD_ZOOM_TELE: begin
        ent_nxt.b3 = GRP_CAMERA;
        ent_nxt.b4 = LENS_TELE;
      end
      CMD_ZOOM_WIDE: begin
        ent_nxt.b3 = GRP_CAMERA;
        ent_nxt.b4 = LENS_WIDE;
      end
      CMD_IRIS_OPEN: begin
        ent_nxt.b3 = GRP_CAMERA;
        ent_nxt.b4 = LENS_IRIS_OPEN;
      end
      CMD_IRIS_CLOSE: begin
        ent_nxt.b3 = GRP_CAMERA;
        ent_nxt.b4 = LENS_IRIS_CLS;
      end
      CMD_FOCUS_FAR: begin
        ent_nxt.b3 = GRP_CAMERA;
        ent_nxt.b4 = LENS_FAR;
      end
      CMD_FOCUS_NEAR: begin
        ent_nxt.b3 = GRP_CAMERA;
        ent_nxt.b4 = LENS_NEAR;
      end
      CMD_STOP: begin
        ent_nxt.b3 = GRP_CAMERA;
        ent_nxt.b4 = LENS_STOP;
      end
      CMD_SET_PRESET, CMD_GOTO_PRESET: begin
        ent_nxt.b3 = GRP_PRESET;
        ent_nxt.b4 = (in_cmd == CMD_SET_PRESET) ? SUB_SET_PRESET : SUB_GOTO;
        ent_nxt.b5 = in_param;
        ent_nxt.b6 = FILL_BYTE;
        ent_nxt.b7 = FILL_BYTE;
      end
      default: begin
        // unknown command: zero body, frame still sent
      end
    endcase
    sum = ent_nxt.addr + ent_nxt.addr + ent_nxt.b3 + ent_nxt.b4
        + ent_nxt.b5 + ent_nxt.b6 + ent_nxt.b7;
    ent_nxt.chk = ~sum;
  end

  // holding stage toward the queue
  always_comb begin
    valid_nxt = valid_r;
    if (accept) valid_nxt = 1'b1;
    else if (q_push) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ent_r <= ent_nxt;
    end
  end

endmodule

FILE: rtl/pcfe_queue.sv
module pcfe_queue
  import pcfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  pcfe_entry_t wdata,
  output logic        full,
  input  logic        pop,
  output logic        valid,
  output pcfe_entry_t rdata
);

  pcfe_entry_t             slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]       cnt_r, cnt_nxt;
  logic                    do_push;
  logic                    do_pop;

  assign full    = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign valid   = (cnt_r != '0);
  assign rdata   = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: rtl/pcfe_back.sv
module pcfe_back
  import pcfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  pcfe_entry_t q_rdata,
  output logic        q_pop,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_frame_byte,
  output logic        out_last
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

  logic              busy_r, busy_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  pcfe_entry_t       ent_r;
  logic              take;
  logic              frame_done;

  assign take       = out_pop && busy_r;
  assign frame_done = take && (idx_r == LAST_IDX);
  assign q_pop      = q_valid && (!busy_r || frame_done);
  assign out_empty  = !busy_r;
  assign out_last   = (idx_r == LAST_IDX);

  // byte sequencer
  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (frame_done) begin
      busy_nxt = 1'b0;
      idx_nxt  = '0;
    end else if (take) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent_r <= q_rdata;
    end
  end

  // pick the byte at the current frame position
  always_comb begin
    case (idx_r)
      IDX_W'(0): out_frame_byte = START_CODE;
      IDX_W'(1): out_frame_byte = ent_r.addr;
      IDX_W'(2): out_frame_byte = ent_r.addr;
      IDX_W'(3): out_frame_byte = ent_r.b3;
      IDX_W'(4): out_frame_byte = ent_r.b4;
      IDX_W'(5): out_frame_byte = ent_r.b5;
      IDX_W'(6): out_frame_byte = ent_r.b6;
      IDX_W'(7): out_frame_byte = ent_r.b7;
      default:   out_frame_byte = ent_r.chk;
    endcase
  end

endmodule

FILE: rtl/ptz_command_frame_encoder_top.sv
// channel   | ports                                   | accepted when
// ----------+-----------------------------------------+------------------------
// input     | in_push, in_full, in_cmd, in_param      | in_push && !in_full
// result    | out_empty, out_pop, out_frame_byte,     | out_pop && !out_empty
//           | out_last                                |
// config    | cfg_valid, cfg_ready, cfg_index,        | cfg_valid && cfg_ready
//           | cfg_data                                |
//
// each command gives nine result bytes, one per cycle while out_pop is held,
// paced by the byte sequencer in the back end; the first byte passes the
// front holding stage, the queue and the back-end busy register before it shows.
// a two-entry queue plus the front holding stage take up to three commands
// ahead of the serializer; in_full rises only when all of them are occupied.
// reset is synchronous, active low, and clears all control state.
module ptz_command_frame_encoder_top
  import pcfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [4:0] in_cmd,
  input  logic [7:0] in_param,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_frame_byte,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  logic [7:0]  device_address_r;
  logic [7:0]  default_speed_r;
  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        q_valid;
  pcfe_entry_t q_wdata;
  pcfe_entry_t q_rdata;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_address_r <= DEVICE_ADDRESS_RST;
      default_speed_r  <= DEFAULT_SPEED_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEVICE_ADDRESS: device_address_r <= cfg_data;
        CFG_DEFAULT_SPEED:  default_speed_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pcfe_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_cmd         (in_cmd),
    .in_param       (in_param),
    .device_address (device_address_r),
    .default_speed  (default_speed_r),
    .q_push         (q_push),
    .q_wdata        (q_wdata),
    .q_full         (q_full)
  );

  pcfe_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  pcfe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_frame_byte (out_frame_byte),
    .out_last       (out_last)
  );

endmodule

FILE: rtl/pcfe_checker.sv
`include "ptz_command_frame_encoder_top_defines.svh"

module pcfe_checker
  import pcfe_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_frame_byte,
  input logic       out_last
);

  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(FRAME_BYTES - 1);

  logic [IDX_W-1:0] pos_r;
  logic [7:0]       sum_r;
  logic             take;

  assign take = out_pop && !out_empty;

  // track position in the frame and the running sum of bytes one to seven
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sum_r <= '0;
    end else if (take) begin
      if (pos_r == LAST_POS) begin
        pos_r <= '0;
        sum_r <= '0;
      end else begin
        pos_r <= pos_r + 1'b1;
        if (pos_r != '0) sum_r <= sum_r + out_frame_byte;
      end
    end
  end

  `PCFE_ASSERT_RST(a_reset_empty, !rst_n |=> out_empty, "result side not empty after reset")

  `PCFE_ASSERT(a_last_pos, !out_empty |-> (out_last == (pos_r == LAST_POS)), "last flag off frame position")

  `PCFE_ASSERT(a_start_code, (!out_empty && pos_r == '0) |-> (out_frame_byte == START_CODE), "frame does not open with start code")

  `PCFE_ASSERT(a_checksum, (!out_empty && out_last) |-> (out_frame_byte == ~sum_r), "checksum mismatch")

  `PCFE_ASSERT(a_hold, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_frame_byte)), "stalled item changed")

endmodule

bind ptz_command_frame_encoder_top pcfe_checker u_pcfe_checker (.*);

FILE: bench/ptz_command_frame_encoder_top_tb.sv
`timescale 1ns / 1ps

module ptz_command_frame_encoder_top_tb;
  import pcfe_pkg::*;

  // command codes past the defined set
  localparam logic [4:0] CMD_UNKNOWN_FIRST = 5'd17;
  localparam logic [4:0] CMD_UNKNOWN_LAST  = 5'd31;

  localparam int ITEMS_PER_PHASE = 31;
  localparam int PHASES          = 6;
  localparam int HOLD_CYCLES     = 80;
  localparam int DRAIN_CYCLES    = 20;
  localparam int IDLE_PCT        = 8;

  // speed steps, direction and lens codes of the frame body
  localparam logic [7:0] RATE_STEPS [0:9] = '{
    8'h0f, 8'h19, 8'h32, 8'h4b, 8'h64, 8'h7d, 8'h96, 8'haf, 8'hc8, 8'hff
  };
  localparam logic [7:0] STEER_CODES [0:7] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h05, 8'h09, 8'h06, 8'h0a
  };
  localparam logic [7:0] LENS_CODES [0:6] = '{
    8'h20, 8'h40, 8'h08, 8'h10, 8'h01, 8'h02, 8'h00
  };

  // settings walked through after the directed part, extremes included
  localparam logic [7:0] PHASE_ADDRESS [0:PHASES-1] = '{
    8'h00, 8'hff, 8'h5a, 8'ha5, 8'h33, 8'hcc
  };
  localparam logic [7:0] PHASE_SPEED [0:PHASES-1] = '{
    8'd0, 8'd255, 8'd9, 8'd10, 8'd109, 8'd110
  };

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last;
  } frame_out_t;

  typedef struct {
    logic [4:0]  cmd;
    logic [7:0]  param;
    bit          typed;
    logic [71:0] frame;
  } command_row_t;

  // directed commands; typed frames assume the reset address and speed
  command_row_t directed_rows [0:23] = '{
    '{CMD_PAN_LEFT,      8'd255, 1'b1, 72'ha0_01_01_01_02_01_ff_00_fa},
    '{CMD_PAN_RIGHT,     8'd1,   1'b1, 72'ha0_01_01_01_02_02_0f_00_e9},
    '{CMD_TILT_UP,       8'd0,   1'b1, 72'ha0_01_01_01_02_04_00_64_92},
    '{CMD_STOP,          8'd0,   1'b1, 72'ha0_01_01_01_00_00_00_00_fc},
    '{CMD_GOTO_PRESET,   8'd255, 1'b1, 72'ha0_01_01_03_19_ff_ff_ff_e4},
    '{CMD_SET_PRESET,    8'd0,   1'b1, 72'ha0_01_01_03_50_00_ff_ff_ac},
    '{CMD_UNKNOWN_LAST,  8'd0,   1'b1, 72'ha0_01_01_00_00_00_00_00_fd},
    '{CMD_TILT_DOWN,     8'd9,   1'b0, 72'h0},
    '{CMD_LEFT_UP,       8'd10,  1'b0, 72'h0},
    '{CMD_LEFT_DOWN,     8'd19,  1'b0, 72'h0},
    '{CMD_RIGHT_UP,      8'd109, 1'b0, 72'h0},
    '{CMD_RIGHT_DOWN,    8'd110, 1'b0, 72'h0},
    '{CMD_ZOOM_TELE,     8'd0,   1'b0, 72'h0},
    '{CMD_ZOOM_WIDE,     8'd255, 1'b0, 72'h0},
    '{CMD_IRIS_OPEN,     8'd7,   1'b0, 72'h0},
    '{CMD_IRIS_CLOSE,    8'd128, 1'b0, 72'h0},
    '{CMD_FOCUS_FAR,     8'd0,   1'b0, 72'h0},
    '{CMD_FOCUS_NEAR,    8'd170, 1'b0, 72'h0},
    '{CMD_SET_PRESET,    8'd255, 1'b0, 72'h0},
    '{CMD_GOTO_PRESET,   8'd1,   1'b0, 72'h0},
    '{CMD_UNKNOWN_FIRST, 8'd85,  1'b0, 72'h0},
    '{CMD_PAN_LEFT,      8'd100, 1'b0, 72'h0},
    '{CMD_TILT_DOWN,     8'd50,  1'b0, 72'h0},
    '{CMD_RIGHT_DOWN,    8'd99,  1'b0, 72'h0}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  logic [4:0] in_cmd = '0;
  logic [7:0] in_param = '0;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic [7:0] out_frame_byte;
  logic       out_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = CFG_DEVICE_ADDRESS;
  logic [7:0] cfg_data = '0;

  // shadow of the device registers
  logic [7:0] cur_address = DEVICE_ADDRESS_RST;
  logic [7:0] cur_default_speed = DEFAULT_SPEED_RST;

  frame_out_t pending_bytes [$];
  int         mismatch_count = 0;
  int         idle_pct = IDLE_PCT;
  bit         hold_request = 1'b0;

  ptz_command_frame_encoder_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_cmd         (in_cmd),
    .in_param       (in_param),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_frame_byte (out_frame_byte),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // speed byte from param, or from the default speed when param is zero
  function automatic logic [7:0] pick_speed(input logic [7:0] param);
    int s;
    int step;
    s = (param != 8'd0) ? int'(param) : int'(cur_default_speed);
    step = (s / 10 == 0) ? 0 : s / 10 - 1;
    if (step > 9) step = 9;
    return RATE_STEPS[step];
  endfunction

  // full nine-byte frame for one command, byte 0 in the top bits
  function automatic logic [71:0] encode_frame(input logic [4:0] cmd,
                                               input logic [7:0] param);
    logic [7:0]  b [0:8];
    logic [7:0]  spd;
    logic [7:0]  sum;
    logic [71:0] f;
    spd = pick_speed(param);
    for (int k = 0; k < 9; k++) b[k] = 8'h00;
    b[0] = 8'ha0;
    b[1] = cur_address;
    b[2] = cur_address;
    if (cmd <= CMD_RIGHT_DOWN) begin
      b[3] = 8'h01;
      b[4] = 8'h02;
      b[5] = STEER_CODES[cmd[2:0]];
      b[6] = (cmd == CMD_TILT_UP || cmd == CMD_TILT_DOWN) ? 8'h00 : spd;
      b[7] = (cmd == CMD_PAN_LEFT || cmd == CMD_PAN_RIGHT) ? 8'h00 : spd;
    end else if (cmd <= CMD_STOP) begin
      b[3] = 8'h01;
      b[4] = LENS_CODES[int'(cmd) - int'(CMD_ZOOM_TELE)];
    end else if (cmd <= CMD_GOTO_PRESET) begin
      b[3] = 8'h03;
      b[4] = (cmd == CMD_SET_PRESET) ? 8'h50 : 8'h19;
      b[5] = param;
      b[6] = 8'hff;
      b[7] = 8'hff;
    end
    sum = 8'h00;
    for (int k = 1; k <= 7; k++) sum = sum + b[k];
    b[8] = sum ^ 8'hff;
    for (int k = 0; k < 9; k++) f[71 - 8 * k -: 8] = b[k];
    return f;
  endfunction

  // offer one command until it is taken, then queue its frame bytes
  task automatic offer_command(input logic [4:0] cmd, input logic [7:0] param,
                               input logic [71:0] frame);
    frame_out_t fb;
    while ($urandom_range(99) < idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push  <= 1'b1;
    in_cmd   <= cmd;
    in_param <= param;
    @(posedge clk);
    while (in_full) @(posedge clk);
    for (int k = 0; k < 9; k++) begin
      fb.frame_byte = frame[71 - 8 * k -: 8];
      fb.last = (k == 8);
      pending_bytes.push_back(fb);
    end
  endtask

  // register write; valid is left high for the caller to drop
  task automatic write_register(input logic idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_DEVICE_ADDRESS) cur_address = data;
    else cur_default_speed = data;
  endtask

  // stop offering and wait for every queued byte to come out
  task automatic drain_frames();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  // param biased toward zero, full scale and the speed step edges
  function automatic logic [7:0] random_param();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(24) * 10 + ($urandom_range(1) ? 9 : 0));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [4:0] random_cmd();
    if ($urandom_range(99) < 85) return 5'($urandom_range(int'(CMD_GOTO_PRESET)));
    return 5'($urandom_range(int'(CMD_UNKNOWN_LAST), int'(CMD_UNKNOWN_FIRST)));
  endfunction

  // receiver: check each popped byte, idle at random, hold off on request
  initial begin
    frame_out_t want;
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        if (pending_bytes.size() == 0) begin
          $error("frame byte %h with nothing expected", out_frame_byte);
          mismatch_count++;
        end else begin
          want = pending_bytes.pop_front();
          if (out_frame_byte !== want.frame_byte) begin
            $error("frame_byte expected %h actual %h", want.frame_byte, out_frame_byte);
            mismatch_count++;
          end
          if (out_last !== want.last) begin
            $error("last expected %b actual %b", want.last, out_last);
            mismatch_count++;
          end
        end
      end
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // stimulus: reset, directed table, then random phases per setting
  initial begin
    logic [4:0] cmd;
    logic [7:0] param;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      offer_command(directed_rows[i].cmd, directed_rows[i].param,
                    directed_rows[i].typed ? directed_rows[i].frame
                      : encode_frame(directed_rows[i].cmd, directed_rows[i].param));
    end
    drain_frames();

    for (int p = 0; p < PHASES; p++) begin
      write_register(CFG_DEVICE_ADDRESS, PHASE_ADDRESS[p]);
      write_register(CFG_DEFAULT_SPEED, PHASE_SPEED[p]);
      cfg_valid <= 1'b0;
      // one phase runs with no idling, one with a long receiver hold-off
      idle_pct = (p == 3) ? 0 : IDLE_PCT;
      if (p == 1) hold_request = 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        cmd = random_cmd();
        param = random_param();
        offer_command(cmd, param, encode_frame(cmd, param));
      end
      drain_frames();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_bytes.size() == 0) begin
      $display("ptz_command_frame_encoder_top_tb OK");
    end else begin
      $display("ptz_command_frame_encoder_top_tb NOT OK");
    end
    $finish;
  end

  // run limit
  initial begin
    #400000;
    $display("ptz_command_frame_encoder_top_tb NOT OK");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/pcfe_pkg.sv
rtl/pcfe_front.sv
rtl/pcfe_queue.sv
rtl/pcfe_back.sv
rtl/ptz_command_frame_encoder_top.sv
rtl/pcfe_checker.sv
bench/ptz_command_frame_encoder_top_tb.sv
